// ----- src/tcw_pkg.sv -----
// Package of the text console writer: operation codes, queue entry type and constants.
package tcw_pkg;

	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned POS_W   = 11;
	localparam int unsigned CELL_W  = 16;
	localparam int unsigned ATTR_W  = 8;

	// Input modes
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Special characters
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd113;

	// Operation decided by the front end
	typedef enum logic [2:0] {
		OP_NOP,
		OP_READ,
		OP_CLEAR,
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_PRINT
	} op_kind_t;

	typedef struct packed {
		op_kind_t             kind;
		logic [CHAR_W-1:0]    char_code;
		logic [INDEX_W-1:0]   cell_index;
		logic                 in_range;
	} op_t;

endpackage

// ----- src/tcw_ifs.sv -----
// Handshake interfaces of the text console writer: command and response channels.
interface tcw_cmd_if
	import tcw_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] cell_index;

	modport source (output valid, mode, char_code, cell_index, input ready);
	modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if
	import tcw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  cursor_pos;
	logic [CELL_W-1:0] cell_data;

	modport source (output valid, cursor_pos, cell_data, input ready);
	modport sink   (input valid, cursor_pos, cell_data, output ready);
endinterface

// ----- src/tcw_front.sv -----
// Front end: accepts command items, classifies them and holds them in a two-entry queue.
module tcw_front
	import tcw_pkg::*;
#(
	parameter int unsigned CELL_COUNT = 2000
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_cmd_if.sink    cmd,
	output logic       op_valid,
	input  logic       op_ready,
	output op_t        op_head
);

	localparam int unsigned DEPTH = 2;

	op_t        fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        op_new;
	logic       push;
	logic       pop;

	// Classify the incoming item
	always_comb begin
		op_new.char_code  = cmd.char_code;
		op_new.cell_index = cmd.cell_index;
		op_new.in_range   = (32'(cmd.cell_index) < 32'(CELL_COUNT));
		case (cmd.mode)
			MODE_WRITE: begin
				unique case (cmd.char_code)
					CHAR_NUL:     op_new.kind = OP_NOP;
					CHAR_NEWLINE: op_new.kind = OP_NEWLINE;
					CHAR_RETURN:  op_new.kind = OP_RETURN;
					CHAR_TAB:     op_new.kind = OP_TAB;
					default:      op_new.kind = OP_PRINT;
				endcase
			end
			MODE_READ:  op_new.kind = OP_READ;
			MODE_CLEAR: op_new.kind = OP_CLEAR;
			default:    op_new.kind = OP_NOP;
		endcase
	end

	assign cmd.ready = (count_q != 2'(DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign op_valid  = (count_q != 2'd0);
	assign pop       = op_valid && op_ready;
	assign op_head   = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op_new;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- src/tcw_back.sv -----
// Back end: screen store, cursor, scroll and clear sequencer, response register.
module tcw_back
	import tcw_pkg::*;
#(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	input  logic          op_valid,
	output logic          op_ready,
	input  op_t           op_head,
	tcw_rsp_if.source     rsp
);

	localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
	localparam int unsigned MOVE_COUNT = COLUMNS * (ROWS - 1);
	localparam int unsigned AW         = $clog2(CELL_COUNT);
	localparam int unsigned CW         = $clog2(COLUMNS + 1);
	localparam int unsigned RW         = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_TAB,
		ST_SCROLL,
		ST_FILL,
		ST_RESP
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      wptr_q;
	logic               pend_q;
	logic               read_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [CELL_W-1:0]  mem [CELL_COUNT];
	logic [CELL_W-1:0]  rdata_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [CELL_W-1:0]  out_data_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [AW-1:0]      cur_addr;
	logic [CW-1:0]      col_inc;
	logic               line_full;
	logic               row_room;
	logic               tab_last;
	logic               out_free;
	logic [CW-1:0]      col_clamp;
	logic [POS_W-1:0]   pos_now;
	state_t             idle_follow;
	state_t             fill_follow;

	assign cur_addr  = AW'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
	assign col_inc   = col_q + CW'(1);
	assign line_full = (col_q == CW'(COLUMNS));
	assign row_room  = (row_q < RW'(ROWS - 2));
	assign tab_last  = (col_inc[1:0] == 2'd0) || (col_inc == CW'(COLUMNS));
	assign out_free  = !out_valid_q || rsp.ready;
	assign col_clamp = line_full ? CW'(COLUMNS - 1) : col_q;
	assign pos_now   = POS_W'(32'(row_q) * 32'(COLUMNS) + 32'(col_clamp));
	assign op_ready  = (state_q == ST_IDLE);

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_pos = out_pos_q;
	assign rsp.cell_data  = out_data_q;

	// Where to go once a line feed is done
	always_comb begin
		case (op_head.kind)
			OP_PRINT: idle_follow = ST_PUT;
			OP_TAB:   idle_follow = ST_TAB;
			default:  idle_follow = ST_RESP;
		endcase
		case (op_q.kind)
			OP_PRINT: fill_follow = ST_PUT;
			OP_TAB:   fill_follow = ST_TAB;
			default:  fill_follow = ST_RESP;
		endcase
	end

	// Store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {attr_q, CHAR_BLANK};
		mem_re    = 1'b0;
		mem_raddr = AW'(32'(ptr_q) + 32'(COLUMNS));
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					if (op_head.kind == OP_READ) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(op_head.cell_index);
					end else if (op_head.kind == OP_PRINT && !line_full) begin
						mem_we    = 1'b1;
						mem_wdata = {attr_q, op_head.char_code};
					end
				end
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {attr_q, op_q.char_code};
			end
			ST_TAB: begin
				mem_we = 1'b1;
			end
			ST_SCROLL: begin
				mem_we    = pend_q;
				mem_waddr = wptr_q;
				mem_wdata = rdata_q;
				mem_re    = (ptr_q != AW'(MOVE_COUNT));
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
			end
			ST_RESP: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Screen store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Payload registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && op_valid) begin
			op_q <= op_head;
		end
		if (state_q == ST_SCROLL) begin
			wptr_q <= ptr_q;
		end
		if (state_q == ST_RESP && out_free) begin
			out_pos_q  <= pos_now;
			out_data_q <= read_q ? rdata_q : '0;
		end
	end

	// Sequencer, cursor, attribute and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			read_q      <= 1'b0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			// Response valid: set as the response register loads, cleared once taken
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						read_q <= (op_head.kind == OP_READ) && op_head.in_range;
						unique case (op_head.kind)
							OP_READ: begin
								state_q <= ST_RESP;
							end
							OP_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								ptr_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_RETURN: begin
								col_q   <= '0;
								state_q <= ST_RESP;
							end
							OP_NEWLINE, OP_TAB, OP_PRINT: begin
								if (op_head.kind == OP_NEWLINE || line_full) begin
									// Line feed, either asked for or from a full line
									col_q <= '0;
									if (row_room) begin
										row_q   <= row_q + RW'(1);
										state_q <= idle_follow;
									end else begin
										ptr_q   <= '0;
										pend_q  <= 1'b0;
										state_q <= ST_SCROLL;
									end
								end else if (op_head.kind == OP_PRINT) begin
									col_q   <= col_inc;
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_TAB;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_PUT: begin
					col_q   <= col_inc;
					state_q <= ST_RESP;
				end
				ST_TAB: begin
					col_q <= col_inc;
					if (tab_last) begin
						state_q <= ST_RESP;
					end
				end
				ST_SCROLL: begin
					// Read one row below, write back in the following cycle
					if (ptr_q != AW'(MOVE_COUNT)) begin
						ptr_q  <= ptr_q + AW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == AW'(CELL_COUNT - 1)) begin
						state_q <= fill_follow;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/text_console_writer.sv -----
// Top level of the text console writer.
// Text console engine with a COLUMNS x ROWS screen of 16-bit cells (attribute in the high
// byte, character in the low byte) and a cursor. Each command item writes a character,
// reads a cell or clears the screen, and gives exactly one response item with the clamped
// cursor position and, for reads, the cell contents. A two-entry queue sits in front of the
// screen store, which has one read and one write port. A tab writes blanks up to the next
// tab stop; a clear fills every cell; a scroll walks the store once, moving each cell up a
// row through a read register and a write-back, then blanks the last row. Cells read before
// any clear or write hold unknown data. The colour attribute register (reset 0x71) should
// only be written while no command is in flight.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	tcw_cmd_if.sink           cmd,
	tcw_rsp_if.source         rsp
);

	logic op_valid;
	logic op_ready;
	op_t  op_head;

	// Command intake and classification
	tcw_front #(
		.CELL_COUNT (COLUMNS * ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op_head  (op_head)
	);

	// Execution against the screen store
	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op_head   (op_head),
		.rsp       (rsp)
	);

endmodule

// ----- dv/text_console_writer_test.sv -----
// Testbench of the text console writer: directed and random command items checked against a screen model.
module text_console_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int unsigned COLUMNS         = 80;
	localparam int unsigned ROWS            = 25;
	localparam int unsigned CELLS           = COLUMNS * ROWS;
	localparam int unsigned TAB_STOP        = 4;
	localparam int unsigned WATCHDOG_LIMIT  = 30000;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES   = 100;
	localparam int unsigned RANDOM_PHASES   = 5;
	localparam int unsigned PHASE_ITEMS     = 120;

	// Mode that the block leaves without effect
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] data;
	} console_resp_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	tcw_cmd_if cmd_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch.sink),
		.rsp       (rsp_ch.source)
	);

	always #6 clk = ~clk;

	// Screen image, cursor and attribute as the block should hold them
	logic [CELL_W-1:0] screen_img [0:CELLS-1];
	bit                cell_known [0:CELLS-1];
	int unsigned       cur_col;
	int unsigned       cur_row;
	logic [ATTR_W-1:0] attr;

	console_resp_t     pending_resps [$];
	int unsigned       fault_count;
	int unsigned       idle_cycles;
	int unsigned       hold_off_request;
	bit                no_gaps;

	function automatic void log_fault(string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	function automatic int unsigned draw_wait();
		if (no_gaps) begin
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	function automatic void store_cell(logic [CHAR_W-1:0] ch);
		screen_img[cur_row * COLUMNS + cur_col] = {attr, ch};
		cell_known[cur_row * COLUMNS + cur_col] = 1'b1;
	endfunction

	// Line feed: move down, or scroll once the row before last is reached
	function automatic void console_newline();
		if (cur_row < ROWS - 2) begin
			cur_row++;
		end else begin
			for (int i = 0; i < CELLS - COLUMNS; i++) begin
				screen_img[i] = screen_img[i + COLUMNS];
				cell_known[i] = cell_known[i + COLUMNS];
			end
			for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
				screen_img[i] = {attr, CHAR_BLANK};
				cell_known[i] = 1'b1;
			end
		end
		cur_col = 0;
	endfunction

	// Apply one command item to the screen image and work out its response
	function automatic console_resp_t predict_console(logic [MODE_W-1:0] mode,
			logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
		console_resp_t r;
		int unsigned   n;
		int unsigned   c;
		int unsigned   rw;
		r.data = '0;
		case (mode)
			MODE_WRITE: begin
				if (ch == CHAR_NEWLINE) begin
					console_newline();
				end else if (ch == CHAR_RETURN) begin
					cur_col = 0;
				end else if (ch == CHAR_TAB) begin
					if (cur_col >= COLUMNS) begin
						console_newline();
					end
					n = TAB_STOP - (cur_col % TAB_STOP);
					repeat (n) begin
						if (cur_col < COLUMNS) begin
							store_cell(CHAR_BLANK);
							cur_col++;
						end
					end
				end else if (ch != CHAR_NUL) begin
					if (cur_col >= COLUMNS) begin
						console_newline();
					end
					store_cell(ch);
					cur_col++;
				end
			end
			MODE_READ: begin
				if (idx < CELLS) begin
					r.data = screen_img[idx];
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_img[i] = {attr, CHAR_BLANK};
					cell_known[i] = 1'b1;
				end
				cur_col = 0;
				cur_row = 0;
			end
			default: ;
		endcase
		c  = (cur_col < COLUMNS) ? cur_col : COLUMNS - 1;
		rw = (cur_row < ROWS) ? cur_row : ROWS - 1;
		r.pos = POS_W'(rw * COLUMNS + c);
		return r;
	endfunction

	// Offer one command item after a random gap and record its response
	task automatic send_command(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
			logic [INDEX_W-1:0] idx);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.mode       <= mode;
		cmd_ch.char_code  <= ch;
		cmd_ch.cell_index <= idx;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_resps.push_back(predict_console(mode, ch, idx));
	endtask

	task automatic send_char(logic [CHAR_W-1:0] ch);
		send_command(MODE_WRITE, ch, INDEX_W'($urandom_range(0, 2047)));
	endtask

	task automatic send_read(logic [INDEX_W-1:0] idx);
		send_command(MODE_READ, CHAR_W'($urandom_range(0, 255)), idx);
	endtask

	task automatic send_clear();
		send_command(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
			INDEX_W'($urandom_range(0, 2047)));
	endtask

	// Stop offering and wait until every response is in
	task automatic wait_drained(int unsigned settle);
		cmd_ch.valid <= 1'b0;
		while (pending_resps.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_attribute(logic [ATTR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr = value;
		@(posedge clk);
	endtask

	// Before any clear: unused mode, ignored null, reads of written cells and past the end
	task automatic test_reset_state();
		send_command(MODE_UNUSED, 8'hFF, 11'h7FF);
		send_char(CHAR_NUL);
		send_char(8'hFF);
		send_char(8'h01);
		send_read(11'd0);
		send_read(11'd1);
		send_read(11'(CELLS));
		send_read(11'h7FF);
		send_command(MODE_UNUSED, 8'h00, 11'd0);
	endtask

	// Extreme attribute values applied to blanks and characters
	task automatic test_attribute_extremes();
		wait_drained(4);
		set_attribute(8'h00);
		send_clear();
		send_char(8'h7F);
		send_char(CHAR_TAB);
		send_read(11'd0);
		send_read(11'd3);
		send_read(11'(CELLS - 1));
		wait_drained(4);
		set_attribute(8'hFF);
		send_char(8'h80);
		send_read(11'd4);
		send_read(11'd5);
		send_char(CHAR_RETURN);
	endtask

	// Carriage return, tab from various columns, line feed
	task automatic test_control_chars();
		send_clear();
		send_char("A");
		send_char(CHAR_TAB);
		send_char(CHAR_TAB);
		send_char(CHAR_RETURN);
		send_char(CHAR_TAB);
		send_char("B");
		send_char(CHAR_NEWLINE);
		send_char("C");
		send_read(11'd1);
		send_read(11'd4);
		send_read(11'd80);
	endtask

	// A full line holds the cursor at the last column until the next character wraps it
	task automatic test_line_wrap();
		send_clear();
		repeat (COLUMNS / TAB_STOP) send_char(CHAR_TAB);
		send_char("Z");
		send_read(11'(COLUMNS));
		repeat (COLUMNS / TAB_STOP - 2) send_char(CHAR_TAB);
		send_char("w");
		send_char("x");
		send_char("y");
		send_char("z");
		send_char("!");
		send_char("?");
		send_char(CHAR_TAB);
		send_read(11'(2 * COLUMNS));
		send_read(11'(2 * COLUMNS + 3));
	endtask

	// Line feeds on the row before last scroll the screen up
	task automatic test_scroll();
		send_clear();
		repeat (ROWS - 2) send_char(CHAR_NEWLINE);
		send_char("S");
		send_read(11'((ROWS - 2) * COLUMNS));
		send_char(CHAR_NEWLINE);
		send_read(11'((ROWS - 3) * COLUMNS));
		send_read(11'((ROWS - 2) * COLUMNS));
		send_read(11'(CELLS - 1));
		send_char("T");
		send_char(CHAR_TAB);
		send_char(CHAR_NEWLINE);
		send_read(11'((ROWS - 3) * COLUMNS));
		send_read(11'((ROWS - 3) * COLUMNS + 2));
	endtask

	// Responses held back for a long stretch so the command side backs up
	task automatic test_input_stall();
		no_gaps = 1'b1;
		hold_off_request = HOLD_OFF_CYCLES;
		for (int i = 0; i < 12; i++) begin
			send_char(CHAR_W'("a" + i));
		end
		send_read(11'((ROWS - 2) * COLUMNS));
		no_gaps = 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] draw_char();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			return CHAR_NEWLINE;
		end else if (pick < 10) begin
			return CHAR_RETURN;
		end else if (pick < 18) begin
			return CHAR_TAB;
		end else if (pick < 20) begin
			return CHAR_NUL;
		end
		return CHAR_W'($urandom_range(1, 255));
	endfunction

	// Mostly character streams, with reads, rare clears and unused modes mixed in
	task automatic test_random_traffic();
		int unsigned       pick;
		logic [INDEX_W-1:0] idx;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained(4);
			case (phase)
				0:       set_attribute(8'hFF);
				1:       set_attribute(8'h00);
				RANDOM_PHASES - 1: set_attribute(ATTR_RESET);
				default: set_attribute(ATTR_W'($urandom_range(0, 255)));
			endcase
			no_gaps = (phase == 2);
			// a burst of line feeds moves the cursor down toward where scrolling happens
			repeat ($urandom_range(3, 12)) send_char(CHAR_NEWLINE);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 199);
				if (pick == 0) begin
					send_clear();
				end else if (pick < 7) begin
					send_command(MODE_UNUSED, CHAR_W'($urandom_range(0, 255)),
						INDEX_W'($urandom_range(0, 2047)));
				end else if (pick < 37) begin
					if ($urandom_range(0, 99) < 85) begin
						idx = INDEX_W'($urandom_range(0, CELLS - 1));
					end else begin
						idx = INDEX_W'($urandom_range(CELLS, 2047));
					end
					// never read a cell that holds nothing yet
					if (idx < CELLS && !cell_known[idx]) begin
						idx = INDEX_W'($urandom_range(CELLS, 2047));
					end
					send_read(idx);
				end else begin
					send_char(draw_char());
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// Response side: random stalls, then check each item against the oldest expectation
	initial begin
		console_resp_t want;
		int unsigned   stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_request != 0) begin
				stall = hold_off_request;
				hold_off_request = 0;
			end else begin
				stall = draw_wait();
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_resps.size() == 0) begin
				log_fault($sformatf("unexpected response pos=%0d data=%h",
					rsp_ch.cursor_pos, rsp_ch.cell_data));
			end else begin
				want = pending_resps.pop_front();
				if (rsp_ch.cursor_pos !== want.pos) begin
					log_fault($sformatf("cursor_pos expected %0d got %0d",
						want.pos, rsp_ch.cursor_pos));
				end
				if (rsp_ch.cell_data !== want.data) begin
					log_fault($sformatf("cell_data expected %h got %h",
						want.data, rsp_ch.cell_data));
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.mode       <= MODE_WRITE;
		cmd_ch.char_code  <= CHAR_NUL;
		cmd_ch.cell_index <= '0;
		fault_count       = 0;
		hold_off_request  = 0;
		no_gaps           = 1'b0;
		cur_col           = 0;
		cur_row           = 0;
		attr              = ATTR_RESET;
		for (int i = 0; i < CELLS; i++) begin
			screen_img[i] = '0;
			cell_known[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_attribute_extremes();
		test_control_chars();
		test_line_wrap();
		test_scroll();
		test_input_stall();
		test_random_traffic();

		wait_drained(SETTLE_CYCLES);
		if (fault_count == 0 && pending_resps.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
